// ----- rtl/core/dsr_pkg.sv -----
package dsr_pkg;

   // table geometry
   localparam int MAX_DEVICES = 16;
   localparam int ID_BITS     = 16;
   localparam int CNT_W       = $clog2(MAX_DEVICES + 1);

   // field widths on the ports
   localparam int MODE_W    = 2;
   localparam int NODE_W    = 16;
   localparam int CODE_W    = 8;
   localparam int STATUS_W  = 2;
   localparam int ENTRIES_W = 5;
   localparam int CSR_IDX_W = 2;

   // request tdata layout, mode travels on tuser
   localparam int REQ_NODE_LSB = 0;
   localparam int REQ_CODE_LSB = REQ_NODE_LSB + NODE_W;
   localparam int REQ_BITS     = REQ_CODE_LSB + CODE_W;
   localparam int REQ_DATA_W   = ((REQ_BITS + 7) / 8) * 8;

   // response tdata layout
   localparam int RSP_ACC_LSB     = 0;
   localparam int RSP_STATUS_LSB  = RSP_ACC_LSB + 1;
   localparam int RSP_INC_LSB     = RSP_STATUS_LSB + STATUS_W;
   localparam int RSP_ENTRIES_LSB = RSP_INC_LSB + 1;
   localparam int RSP_BITS        = RSP_ENTRIES_LSB + ENTRIES_W;
   localparam int RSP_DATA_W      = ((RSP_BITS + 7) / 8) * 8;

   // item modes
   localparam logic [MODE_W-1:0] MODE_REPORT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_POLL   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ALARM      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FAIL       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ALARM_FAIL = 2'd2;

   // register reset values
   localparam logic [CODE_W-1:0] ALARM_RST      = 8'd1;
   localparam logic [CODE_W-1:0] FAIL_RST       = 8'd2;
   localparam logic [CODE_W-1:0] ALARM_FAIL_RST = 8'd3;

   typedef struct packed {
      logic [CODE_W-1:0] alarm;
      logic [CODE_W-1:0] fail;
      logic [CODE_W-1:0] alarm_fail;
   } cfg_type;

   // transaction token walking down the cell row
   typedef struct packed {
      logic               vld;
      logic               poll;
      logic [ID_BITS-1:0] id;
      logic [CODE_W-1:0]  code;
      logic [CNT_W-1:0]   pos;
      logic               found;
      logic               appended;
      logic               alarm;
      logic               fail;
      logic               stop;
      logic               miss;
   } token_type;

   // finished transaction waiting for the output register
   typedef struct packed {
      logic                accepted;
      logic [STATUS_W-1:0] status;
      logic                miss;
      logic                appended;
      logic                clear;
   } pend_type;

endpackage

// ----- rtl/core/dsr_cell.sv -----
module dsr_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  dsr_pkg::cfg_type      cfg_i,
   input  logic [dsr_pkg::CNT_W-1:0] count_i,
   input  dsr_pkg::token_type    tok_i,
   output dsr_pkg::token_type    tok_o
);

   logic [dsr_pkg::ID_BITS-1:0] id_ff, id_in;
   logic [dsr_pkg::CODE_W-1:0]  code_ff, code_in;
   logic                        fresh_ff, fresh_in;
   dsr_pkg::token_type          tok_ff, tok_in;
   logic                        live;

   // entry is part of the table when its position is below the count
   assign live = tok_i.vld && (tok_i.pos < count_i);

   always_comb begin
      tok_in     = tok_i;
      tok_in.pos = dsr_pkg::CNT_W'(tok_i.pos + 1'b1);
      id_in      = id_ff;
      code_in    = code_ff;
      fresh_in   = fresh_ff;

      // report: overwrite on hit, append at the first free slot
      if (tok_i.vld && !tok_i.poll) begin
         if (live && (id_ff == tok_i.id)) begin
            code_in      = tok_i.code;
            fresh_in     = 1'b1;
            tok_in.found = 1'b1;
         end else if ((tok_i.pos == count_i) && !tok_i.found) begin
            id_in           = tok_i.id;
            code_in         = tok_i.code;
            fresh_in        = 1'b1;
            tok_in.found    = 1'b1;
            tok_in.appended = 1'b1;
         end
      end

      // poll: fold fresh codes until the first alarm-and-fail entry
      if (live && tok_i.poll) begin
         if (tok_i.stop || !fresh_ff) begin
            tok_in.miss = 1'b1;
         end else begin
            fresh_in = 1'b0;
            if (code_ff == cfg_i.alarm_fail) begin
               tok_in.alarm = 1'b1;
               tok_in.fail  = 1'b1;
               tok_in.stop  = 1'b1;
            end else begin
               if (code_ff == cfg_i.alarm) tok_in.alarm = 1'b1;
               if (code_ff == cfg_i.fail)  tok_in.fail  = 1'b1;
            end
         end
      end
   end

   // control state and token
   always_ff @(posedge clock) begin
      if (reset) begin
         fresh_ff <= 1'b0;
         tok_ff   <= '0;
      end else begin
         fresh_ff <= fresh_in;
         tok_ff   <= tok_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      id_ff   <= id_in;
      code_ff <= code_in;
   end

   assign tok_o = tok_ff;

endmodule

// ----- rtl/core/device_status_registry.sv -----
// Device status registry. The table lives in a row of MAX_DEVICES cells, one
// device entry per cell; a report or poll transaction enters the first cell
// and moves one cell per clock, and the next request is taken only after it
// has left the last cell and its response is loaded into the output register.
// Clear and unused-mode requests skip the row. One request is worked on at a
// time; a finished response waits in the output register while the next
// request runs. Register writes on the csr port are always taken and must
// only happen while no request is outstanding.
module device_status_registry (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // req_tdata: node_id[15:0], status_code[23:16]
   input  logic [dsr_pkg::REQ_DATA_W-1:0]     req_tdata,
   // req_tuser: mode[1:0]
   input  logic [dsr_pkg::MODE_W-1:0]         req_tuser,
   // rsp_tdata: accepted[0], overall_status[2:1], incomplete[3], entries[8:4], zero fill
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [dsr_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [dsr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dsr_pkg::CODE_W-1:0]         csr_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   logic [1:0]                      state_ff, state_in;
   dsr_pkg::cfg_type                cfg_ff, cfg_in;
   logic [dsr_pkg::CNT_W-1:0]       count_ff, count_in;
   logic                            incomplete_ff, incomplete_in;
   dsr_pkg::token_type              launch_ff, launch_in;
   dsr_pkg::pend_type               pend_ff, pend_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [dsr_pkg::RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   dsr_pkg::token_type              link [dsr_pkg::MAX_DEVICES+1];
   logic                            req_take;
   logic [dsr_pkg::MODE_W-1:0]      req_mode;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign req_mode   = req_tuser;
   assign csr_ready  = 1'b1;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            dsr_pkg::REG_ALARM:      cfg_in.alarm      = csr_data;
            dsr_pkg::REG_FAIL:       cfg_in.fail       = csr_data;
            dsr_pkg::REG_ALARM_FAIL: cfg_in.alarm_fail = csr_data;
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   // cell row
   assign link[0] = launch_ff;

   for (genvar g = 0; g < dsr_pkg::MAX_DEVICES; g++) begin : g_cell
      dsr_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .cfg_i   (cfg_ff),
         .count_i (count_ff),
         .tok_i   (link[g]),
         .tok_o   (link[g+1])
      );
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      launch_in     = launch_ff;
      launch_in.vld = 1'b0;
      pend_in       = pend_ff;
      count_in      = count_ff;
      incomplete_in = incomplete_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if ((req_mode == dsr_pkg::MODE_REPORT) || (req_mode == dsr_pkg::MODE_POLL)) begin
                  launch_in.vld      = 1'b1;
                  launch_in.poll     = (req_mode == dsr_pkg::MODE_POLL);
                  launch_in.id       = dsr_pkg::ID_BITS'(
                     req_tdata[dsr_pkg::REQ_NODE_LSB +: dsr_pkg::NODE_W]);
                  launch_in.code     = req_tdata[dsr_pkg::REQ_CODE_LSB +: dsr_pkg::CODE_W];
                  launch_in.pos      = '0;
                  launch_in.found    = 1'b0;
                  launch_in.appended = 1'b0;
                  launch_in.alarm    = 1'b0;
                  launch_in.fail     = 1'b0;
                  launch_in.stop     = 1'b0;
                  launch_in.miss     = 1'b0;
                  state_in           = ST_RUN;
               end else begin
                  pend_in  = '0;
                  pend_in.clear = (req_mode == dsr_pkg::MODE_CLEAR);
                  state_in = ST_FIN;
               end
            end
         end
         ST_RUN: begin
            if (link[dsr_pkg::MAX_DEVICES].vld) begin
               pend_in.accepted = !link[dsr_pkg::MAX_DEVICES].poll &&
                                  link[dsr_pkg::MAX_DEVICES].found;
               pend_in.status   = link[dsr_pkg::MAX_DEVICES].poll ?
                                  {link[dsr_pkg::MAX_DEVICES].fail,
                                   link[dsr_pkg::MAX_DEVICES].alarm} : 2'b00;
               pend_in.miss     = link[dsr_pkg::MAX_DEVICES].poll &&
                                  link[dsr_pkg::MAX_DEVICES].miss;
               pend_in.appended = link[dsr_pkg::MAX_DEVICES].appended;
               pend_in.clear    = 1'b0;
               state_in         = ST_FIN;
            end
         end
         ST_FIN: begin
            // commit state and load the output register once it is free
            if (!rsp_valid_ff || rsp_tready) begin
               if (pend_ff.clear) begin
                  count_in = '0;
               end else if (pend_ff.appended) begin
                  count_in = dsr_pkg::CNT_W'(count_ff + 1'b1);
               end
               incomplete_in = incomplete_ff || pend_ff.miss;
               rsp_data_in   = '0;
               rsp_data_in[dsr_pkg::RSP_ACC_LSB]                         = pend_ff.accepted;
               rsp_data_in[dsr_pkg::RSP_STATUS_LSB +: dsr_pkg::STATUS_W] = pend_ff.status;
               rsp_data_in[dsr_pkg::RSP_INC_LSB]                         = incomplete_in;
               rsp_data_in[dsr_pkg::RSP_ENTRIES_LSB +: dsr_pkg::ENTRIES_W] =
                  dsr_pkg::ENTRIES_W'(count_in);
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         cfg_ff.alarm      <= dsr_pkg::ALARM_RST;
         cfg_ff.fail       <= dsr_pkg::FAIL_RST;
         cfg_ff.alarm_fail <= dsr_pkg::ALARM_FAIL_RST;
         count_ff          <= '0;
         incomplete_ff     <= 1'b0;
         launch_ff         <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cfg_ff        <= cfg_in;
         count_ff      <= count_in;
         incomplete_ff <= incomplete_in;
         launch_ff     <= launch_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- rtl/core/dsr_checker.sv -----
module dsr_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [dsr_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   // a stalled response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("response changed while stalled");

   // one request at a time: no back-to-back acceptance
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while one is in flight");

   // stored count never exceeds the table size
   a_entries_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         (rsp_tdata[dsr_pkg::RSP_ENTRIES_LSB +: dsr_pkg::ENTRIES_W] <=
          dsr_pkg::ENTRIES_W'(dsr_pkg::MAX_DEVICES)))
      else $error("entry count out of range");

   // a poll status never comes with an accepted report
   a_status_excl: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid &&
       (rsp_tdata[dsr_pkg::RSP_STATUS_LSB +: dsr_pkg::STATUS_W] != 2'b00)) |->
         !rsp_tdata[dsr_pkg::RSP_ACC_LSB])
      else $error("status and accepted both set");

endmodule

bind device_status_registry dsr_checker u_dsr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
